>>> rtl/core/atpc_pkg.sv
package atpc_pkg;

    // number format
    localparam int COORD_WIDTH = 32;
    localparam int FRAC_BITS   = 16;

    // floored product width and the clamp that applies to very wide products
    localparam int RAW_W    = 2 * COORD_WIDTH - FRAC_BITS;
    localparam int TERM_W   = (RAW_W > 62) ? 62 : RAW_W;
    localparam bit CLAMP_ON = (RAW_W > 61);
    localparam int SUM_W    = ((TERM_W > COORD_WIDTH) ? TERM_W : COORD_WIDTH) + 2;

    localparam int NUM_AXES = 3;
    localparam int ROW_W    = 2;
    localparam int CFG_IDX_W = 3;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;
    typedef logic signed [TERM_W-1:0]      term_t;
    typedef logic signed [SUM_W-1:0]       sum_t;
    typedef logic signed [RAW_W-1:0]       raw_t;

    localparam coord_t C_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam coord_t C_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};
    localparam raw_t   TERM_LIM = RAW_W'(65'sd1 << 60);

    typedef enum logic {
        FUNC_LOAD  = 1'b0,
        FUNC_PLANE = 1'b1
    } func_t;

    localparam logic [ROW_W-1:0] ROW_TRANS = 2'd3;

    typedef enum logic [1:0] {
        SIDE_BACK  = 2'd0,
        SIDE_FRONT = 2'd1,
        SIDE_ISECT = 2'd2
    } side_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_X = 3'd0,
        CFG_MIN_Y = 3'd1,
        CFG_MIN_Z = 3'd2,
        CFG_MAX_X = 3'd3,
        CFG_MAX_Y = 3'd4,
        CFG_MAX_Z = 3'd5
    } cfg_idx_t;

    // box corners, index 0..2 is x, y, z
    typedef struct packed {
        coord_t [NUM_AXES-1:0] lo;
        coord_t [NUM_AXES-1:0] hi;
    } box_t;

    // multiply stage results, one entry per transaction in flight
    typedef struct packed {
        logic                               is_plane;
        logic                               rebuild;
        coord_t [NUM_AXES-1:0]              base;      // translation row, or d in base[0]
        term_t  [NUM_AXES-1:0][NUM_AXES-1:0] lo_term;  // [out axis][in axis]
        term_t  [NUM_AXES-1:0][NUM_AXES-1:0] hi_term;
        term_t  [NUM_AXES-1:0]              far_term;
        term_t  [NUM_AXES-1:0]              near_term;
    } mul_res_t;

    // fixed point product, floored; clamped to +-2^60 only when CLAMP_ON is set
    function automatic term_t qterm(coord_t a, coord_t b);
        logic signed [2*COORD_WIDTH-1:0] prod;
        raw_t raw;
        prod = a * b;
        raw  = RAW_W'(prod >>> FRAC_BITS);
        if (CLAMP_ON) begin
            if (raw > TERM_LIM) begin
                raw = TERM_LIM;
            end else if (raw < -TERM_LIM) begin
                raw = -TERM_LIM;
            end
        end
        return TERM_W'(raw);
    endfunction

    function automatic coord_t sat_coord(sum_t s);
        coord_t r;
        if (s > C_MAX) begin
            r = C_MAX;
        end else if (s < C_MIN) begin
            r = C_MIN;
        end else begin
            r = COORD_WIDTH'(s);
        end
        return r;
    endfunction

endpackage

>>> rtl/core/aabb_transform_plane_classify_unit.sv
// channel   | direction | handshake           | payload
// ----------+-----------+---------------------+-----------------------------------------
// cfg       | in        | cfg_valid/cfg_ready | cfg_index, cfg_data (local box corner)
// s_        | in        | s_valid/s_ready     | s_func, s_row_index, s_coef_0..s_coef_3
// m_        | out       | m_valid/m_ready     | m_side (one per plane transaction)
//
// one transaction accepted per cycle unless stalled; a plane transaction just behind a
//   translation-row load is held until the world box register has updated
// registers in order are the input register, multiply register and result register
// reset is synchronous; clears valids, the local box and the world box; matrix rows are
//   not reset and hold whatever was last loaded
// a stalled m_ channel holds the result register; plane items back up both stages
// cfg_ready is always high
module aabb_transform_plane_classify_unit (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // configuration
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [atpc_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  atpc_pkg::coord_t                      cfg_data,
    // input transactions
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic                                  s_func,
    input  logic [atpc_pkg::ROW_W-1:0]            s_row_index,
    input  atpc_pkg::coord_t                      s_coef_0,
    input  atpc_pkg::coord_t                      s_coef_1,
    input  atpc_pkg::coord_t                      s_coef_2,
    input  atpc_pkg::coord_t                      s_coef_3,
    // results
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [1:0]                            m_side
);

    // local box from configuration, world box rebuilt on translation row
    atpc_pkg::box_t local_box_reg;
    atpc_pkg::box_t world_box_reg;
    atpc_pkg::box_t new_box;

    // linear part of the matrix, rows 0..2
    atpc_pkg::coord_t [atpc_pkg::NUM_AXES-1:0][atpc_pkg::NUM_AXES-1:0] mat_reg;

    // input register stage
    logic                              a_valid_reg;
    logic                              a_valid_next;
    atpc_pkg::func_t                   a_func_reg;
    logic [atpc_pkg::ROW_W-1:0]        a_row_reg;
    atpc_pkg::coord_t [3:0]            a_coef_reg;
    logic                              a_rebuild;

    // multiply stage output
    logic                              b_valid_reg;
    logic                              b_valid_next;
    atpc_pkg::mul_res_t                b_res;

    // result register
    logic                              m_valid_reg;
    logic                              m_valid_next;
    atpc_pkg::side_t                   m_side_reg;
    atpc_pkg::side_t                   side;

    // flow control
    logic out_free;
    logic b_plane;
    logic b_adv;
    logic b_free;
    logic hazard;
    logic a_adv;
    logic s_fire;

    assign cfg_ready = 1'b1;

    assign out_free  = !m_valid_reg || m_ready;
    assign b_plane   = b_valid_reg && b_res.is_plane;
    assign b_adv     = b_valid_reg && (!b_res.is_plane || out_free);
    assign b_free    = !b_valid_reg || b_adv;
    // plane test must see the box that a rebuild in the reduce stage is producing
    assign hazard    = (a_func_reg == atpc_pkg::FUNC_PLANE) && b_valid_reg && b_res.rebuild;
    assign a_adv     = a_valid_reg && b_free && !hazard;
    assign s_ready   = !a_valid_reg || a_adv;
    assign s_fire    = s_valid && s_ready;

    assign a_rebuild = (a_func_reg == atpc_pkg::FUNC_LOAD) && (a_row_reg == atpc_pkg::ROW_TRANS);

    always_comb begin
        a_valid_next = a_valid_reg;
        if (s_fire) begin
            a_valid_next = 1'b1;
        end else if (a_adv) begin
            a_valid_next = 1'b0;
        end
        b_valid_next = b_valid_reg;
        if (a_adv) begin
            b_valid_next = 1'b1;
        end else if (b_adv) begin
            b_valid_next = 1'b0;
        end
        m_valid_next = out_free ? b_plane : m_valid_reg;
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // configuration registers, indexes past the last corner are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            local_box_reg <= '0;
        end else if (cfg_valid) begin
            unique case (atpc_pkg::cfg_idx_t'(cfg_index))
                atpc_pkg::CFG_MIN_X: local_box_reg.lo[0] <= cfg_data;
                atpc_pkg::CFG_MIN_Y: local_box_reg.lo[1] <= cfg_data;
                atpc_pkg::CFG_MIN_Z: local_box_reg.lo[2] <= cfg_data;
                atpc_pkg::CFG_MAX_X: local_box_reg.hi[0] <= cfg_data;
                atpc_pkg::CFG_MAX_Y: local_box_reg.hi[1] <= cfg_data;
                atpc_pkg::CFG_MAX_Z: local_box_reg.hi[2] <= cfg_data;
                default: ;
            endcase
        end
    end

    // matrix rows are written at accept, so the rebuild sees every earlier row
    always_ff @(posedge aclk) begin
        if (s_fire && (atpc_pkg::func_t'(s_func) == atpc_pkg::FUNC_LOAD)
                && (s_row_index != atpc_pkg::ROW_TRANS)) begin
            mat_reg[s_row_index][0] <= s_coef_0;
            mat_reg[s_row_index][1] <= s_coef_1;
            mat_reg[s_row_index][2] <= s_coef_2;
        end
    end

    // input register payload
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            a_func_reg    <= atpc_pkg::func_t'(s_func);
            a_row_reg     <= s_row_index;
            a_coef_reg[0] <= s_coef_0;
            a_coef_reg[1] <= s_coef_1;
            a_coef_reg[2] <= s_coef_2;
            a_coef_reg[3] <= s_coef_3;
        end
    end

    atpc_mul_stage u_mul (
        .aclk      (aclk),
        .adv       (a_adv),
        .a_func    (a_func_reg),
        .a_rebuild (a_rebuild),
        .a_coef    (a_coef_reg),
        .mat       (mat_reg),
        .local_box (local_box_reg),
        .world_box (world_box_reg),
        .res_reg   (b_res)
    );

    atpc_reduce_stage u_reduce (
        .res     (b_res),
        .new_box (new_box),
        .side    (side)
    );

    // world box updates as the rebuild leaves the reduce stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            world_box_reg <= '0;
        end else if (b_adv && b_res.rebuild) begin
            world_box_reg <= new_box;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free && b_plane) begin
            m_side_reg <= side;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_side  = m_side_reg;

endmodule

>>> rtl/core/atpc_mul_stage.sv
module atpc_mul_stage (
    input  logic                                                  aclk,
    input  logic                                                  adv,
    input  atpc_pkg::func_t                                       a_func,
    input  logic                                                  a_rebuild,
    input  atpc_pkg::coord_t [3:0]                                a_coef,
    input  atpc_pkg::coord_t [atpc_pkg::NUM_AXES-1:0][atpc_pkg::NUM_AXES-1:0] mat,
    input  atpc_pkg::box_t                                        local_box,
    input  atpc_pkg::box_t                                        world_box,
    output atpc_pkg::mul_res_t                                    res_reg
);

    atpc_pkg::mul_res_t res_next;

    always_comb begin
        atpc_pkg::coord_t ord_lo;
        atpc_pkg::coord_t ord_hi;
        atpc_pkg::coord_t m;
        atpc_pkg::coord_t k;
        res_next          = '0;
        res_next.is_plane = (a_func == atpc_pkg::FUNC_PLANE);
        res_next.rebuild  = a_rebuild;
        if (a_func == atpc_pkg::FUNC_PLANE) begin
            res_next.base[0] = a_coef[3];
        end else begin
            for (int j = 0; j < atpc_pkg::NUM_AXES; j++) begin
                res_next.base[j] = a_coef[j];
            end
        end
        // box bounds: per term the extreme corner follows the sign of the matrix entry
        for (int i = 0; i < atpc_pkg::NUM_AXES; i++) begin
            if ($signed(local_box.lo[i]) <= $signed(local_box.hi[i])) begin
                ord_lo = local_box.lo[i];
                ord_hi = local_box.hi[i];
            end else begin
                ord_lo = local_box.hi[i];
                ord_hi = local_box.lo[i];
            end
            for (int j = 0; j < atpc_pkg::NUM_AXES; j++) begin
                m = mat[i][j];
                if (m >= 0) begin
                    res_next.lo_term[j][i] = atpc_pkg::qterm(ord_lo, m);
                    res_next.hi_term[j][i] = atpc_pkg::qterm(ord_hi, m);
                end else begin
                    res_next.lo_term[j][i] = atpc_pkg::qterm(ord_hi, m);
                    res_next.hi_term[j][i] = atpc_pkg::qterm(ord_lo, m);
                end
            end
        end
        // plane: far corner on the positive side of the normal
        for (int j = 0; j < atpc_pkg::NUM_AXES; j++) begin
            k = a_coef[j];
            if (k > 0) begin
                res_next.far_term[j]  = atpc_pkg::qterm(k, world_box.hi[j]);
                res_next.near_term[j] = atpc_pkg::qterm(k, world_box.lo[j]);
            end else begin
                res_next.far_term[j]  = atpc_pkg::qterm(k, world_box.lo[j]);
                res_next.near_term[j] = atpc_pkg::qterm(k, world_box.hi[j]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            res_reg <= res_next;
        end
    end

endmodule

>>> rtl/core/atpc_reduce_stage.sv
module atpc_reduce_stage (
    input  atpc_pkg::mul_res_t res,
    output atpc_pkg::box_t     new_box,
    output atpc_pkg::side_t    side
);

    atpc_pkg::sum_t far_sum;
    atpc_pkg::sum_t near_sum;

    always_comb begin
        atpc_pkg::sum_t lo_sum;
        atpc_pkg::sum_t hi_sum;
        for (int j = 0; j < atpc_pkg::NUM_AXES; j++) begin
            lo_sum = atpc_pkg::SUM_W'($signed(res.base[j]));
            hi_sum = atpc_pkg::SUM_W'($signed(res.base[j]));
            for (int i = 0; i < atpc_pkg::NUM_AXES; i++) begin
                lo_sum = lo_sum + atpc_pkg::SUM_W'($signed(res.lo_term[j][i]));
                hi_sum = hi_sum + atpc_pkg::SUM_W'($signed(res.hi_term[j][i]));
            end
            new_box.lo[j] = atpc_pkg::sat_coord(lo_sum);
            new_box.hi[j] = atpc_pkg::sat_coord(hi_sum);
        end
    end

    always_comb begin
        far_sum  = atpc_pkg::SUM_W'($signed(res.base[0]));
        near_sum = atpc_pkg::SUM_W'($signed(res.base[0]));
        for (int j = 0; j < atpc_pkg::NUM_AXES; j++) begin
            far_sum  = far_sum + atpc_pkg::SUM_W'($signed(res.far_term[j]));
            near_sum = near_sum + atpc_pkg::SUM_W'($signed(res.near_term[j]));
        end
        priority if (far_sum < 0) begin
            side = atpc_pkg::SIDE_BACK;
        end else if (near_sum > 0) begin
            side = atpc_pkg::SIDE_FRONT;
        end else begin
            side = atpc_pkg::SIDE_ISECT;
        end
    end

endmodule

>>> rtl/core/atpc_checker.sv
module atpc_checker (
    input logic                                  aclk,
    input logic                                  aresetn,
    input logic                                  cfg_ready,
    input logic                                  s_valid,
    input logic                                  s_ready,
    input logic                                  s_func,
    input logic                                  m_valid,
    input logic                                  m_ready,
    input logic [1:0]                            m_side
);

    // plane transactions accepted and not yet delivered
    logic [2:0] pend_reg;
    logic [2:0] pend_next;
    logic       in_plane;
    logic       out_fire;

    assign in_plane = s_valid && s_ready && (atpc_pkg::func_t'(s_func) == atpc_pkg::FUNC_PLANE);
    assign out_fire = m_valid && m_ready;

    always_comb begin
        pend_next = pend_reg;
        if (in_plane && !out_fire) begin
            pend_next = pend_reg + 3'd1;
        end else if (!in_plane && out_fire) begin
            pend_next = pend_reg - 3'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= '0;
        end else begin
            pend_reg <= pend_next;
        end
    end

    // stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_side))
        else $error("result changed while stalled");

    // no result without a plane transaction behind it
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> pend_reg != 3'd0)
        else $error("result without pending plane transaction");

    // two stages plus the result register bound what is in flight
    assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg <= 3'd3)
        else $error("more plane transactions in flight than stages");

    assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_ready)
        else $error("configuration port not ready");

endmodule

bind aabb_transform_plane_classify_unit atpc_checker u_atpc_checker (.*);
